FILE: hdl/gmm_pkg.sv
package gmm_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned HalfW = 32;

	localparam logic [WordW-1:0] GL_PRIME   = 64'hFFFF_FFFF_0000_0001;
	localparam logic [WordW-1:0] GL_EPSILON = 64'h0000_0000_FFFF_FFFF;
	localparam logic [WordW-1:0] GL_HI_MAX  = 64'hFFFF_FFFF_FFFF_FFFE;

	typedef logic [WordW-1:0] word_t;
	typedef logic [HalfW-1:0] half_t;

endpackage

FILE: hdl/goldilocks_mod_multiplier.sv
// Throughput: one item per cycle while the output is not stalled;
// two partial-product/combine stages and three reduction stages,
// each stage advancing whenever the next one frees up.
// Reset: arst_n clears all stage valid bits at once; data registers are not reset.
module goldilocks_mod_multiplier (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // [63:0] operand_a, [127:64] operand_b
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata   // [63:0] product_mod_p
);
	import gmm_pkg::*;

	logic  mul_valid, mul_ready;
	word_t mul_hi, mul_lo;

	gmm_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.a         (s_axis_tdata[63:0]),
		.b         (s_axis_tdata[127:64]),
		.out_valid (mul_valid),
		.out_ready (mul_ready),
		.hi        (mul_hi),
		.lo        (mul_lo)
	);

	gmm_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mul_valid),
		.in_ready  (mul_ready),
		.hi        (mul_hi),
		.lo        (mul_lo),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res       (m_axis_tdata)
	);

endmodule

FILE: hdl/gmm_mul.sv
module gmm_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  gmm_pkg::word_t a,
	input  gmm_pkg::word_t b,
	output logic         out_valid,
	input  logic         out_ready,
	output gmm_pkg::word_t hi,
	output gmm_pkg::word_t lo
);
	import gmm_pkg::*;

	logic   v_s1, v_s2;
	logic   en_s1, en_s2;
	word_t  p00_s1, p01_s1, p10_s1, p11_s1;
	word_t  hi_s2, lo_s2;
	logic [HalfW+1:0] mid;
	word_t  hi_d, lo_d;

	assign en_s2 = !v_s2 || out_ready;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			p00_s1 <= word_t'(a[HalfW-1:0]) * word_t'(b[HalfW-1:0]);
			p01_s1 <= word_t'(a[HalfW-1:0]) * word_t'(b[WordW-1:HalfW]);
			p10_s1 <= word_t'(a[WordW-1:HalfW]) * word_t'(b[HalfW-1:0]);
			p11_s1 <= word_t'(a[WordW-1:HalfW]) * word_t'(b[WordW-1:HalfW]);
		end
	end

	always_comb begin
		mid = {2'b00, p00_s1[WordW-1:HalfW]} + {2'b00, p01_s1[HalfW-1:0]}
			+ {2'b00, p10_s1[HalfW-1:0]};
		lo_d = {mid[HalfW-1:0], p00_s1[HalfW-1:0]};
		hi_d = p11_s1 + word_t'(p01_s1[WordW-1:HalfW]) + word_t'(p10_s1[WordW-1:HalfW])
			+ word_t'(mid[HalfW+1:HalfW]);
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			hi_s2 <= hi_d;
			lo_s2 <= lo_d;
		end
	end

	assign out_valid = v_s2;
	assign hi = hi_s2;
	assign lo = lo_s2;

`ifndef NO_ASSERTIONS
	a_hi_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> hi_s2 <= GL_HI_MAX)
		else $error("high product half out of range");
`endif

endmodule

FILE: hdl/gmm_reduce.sv
module gmm_reduce (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  gmm_pkg::word_t hi,
	input  gmm_pkg::word_t lo,
	output logic         out_valid,
	input  logic         out_ready,
	output gmm_pkg::word_t res
);
	import gmm_pkg::*;

	logic   v_s1, v_s2, v_s3;
	logic   en_s1, en_s2, en_s3;
	word_t  t0_s1, t1_s1, t2_s2, res_s3;
	logic [WordW:0] diff, sum;
	word_t  t0_d, t1_d, t2_d, res_d;

	assign en_s3 = !v_s3 || out_ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_comb begin
		diff = {1'b0, lo} - {1'b0, word_t'(hi[WordW-1:HalfW])};
		t0_d = diff[WordW] ? (diff[WordW-1:0] - GL_EPSILON) : diff[WordW-1:0];
		t1_d = {hi[HalfW-1:0], {HalfW{1'b0}}} - word_t'(hi[HalfW-1:0]);
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			t0_s1 <= t0_d;
			t1_s1 <= t1_d;
		end
	end

	always_comb begin
		sum = {1'b0, t0_s1} + {1'b0, t1_s1};
		t2_d = sum[WordW] ? (sum[WordW-1:0] + GL_EPSILON) : sum[WordW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) t2_s2 <= t2_d;
	end

	assign res_d = (t2_s2 >= GL_PRIME) ? (t2_s2 - GL_PRIME) : t2_s2;

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) res_s3 <= res_d;
	end

	assign out_valid = v_s3;
	assign res = res_s3;

`ifndef NO_ASSERTIONS
	a_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> res_s3 < GL_PRIME)
		else $error("result not canonical");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !out_ready |=> v_s3 && $stable(res_s3))
		else $error("stalled result lost or changed");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && !out_ready |-> !in_ready)
		else $error("input taken while pipeline full");
`endif

endmodule

FILE: tb/sv/tb.sv
module tb;
	import gmm_pkg::*;

	localparam int unsigned TotalItems = 1250;
	localparam int unsigned HoldAtItem = 400;
	localparam int unsigned HoldCycles = 300;
	localparam int unsigned IdleLimit  = 4000;
	localparam int unsigned DrainCycles = 12;
	localparam int unsigned MaxReports = 20;

	localparam word_t Top      = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam word_t PrimeM1  = 64'hFFFF_FFFF_0000_0000;
	localparam word_t PrimeM2  = 64'hFFFF_FFFE_FFFF_FFFF;
	localparam word_t PrimeP1  = 64'hFFFF_FFFF_0000_0002;
	localparam word_t Two32    = 64'h0000_0001_0000_0000;

	typedef struct packed {
		word_t op_a;
		word_t op_b;
		logic  known;
		word_t product;
	} dir_row_t;

	localparam int unsigned DirRows = 20;
	localparam dir_row_t DirTab [DirRows] = '{
		'{64'd0,      64'd0,      1'b1, 64'd0},
		'{64'd0,      Top,        1'b1, 64'd0},
		'{Top,        64'd0,      1'b1, 64'd0},
		'{64'd1,      64'd1,      1'b1, 64'd1},
		'{64'd1,      Top,        1'b1, 64'h0000_0000_FFFF_FFFE},
		'{Top,        64'd1,      1'b1, 64'h0000_0000_FFFF_FFFE},
		'{GL_PRIME,   Top,        1'b1, 64'd0},
		'{GL_PRIME,   GL_PRIME,   1'b1, 64'd0},
		'{PrimeP1,    PrimeP1,    1'b1, 64'd1},
		'{PrimeM1,    PrimeM1,    1'b1, 64'd1},
		'{PrimeM1,    64'd1,      1'b1, PrimeM1},
		'{PrimeM1,    64'd2,      1'b1, PrimeM2},
		'{Two32,      Two32,      1'b1, GL_EPSILON},
		'{Top,        Top,        1'b0, 64'd0},
		'{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0, 64'd0},
		'{GL_EPSILON, GL_EPSILON, 1'b0, 64'd0},
		'{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 64'd0},
		'{GL_PRIME + 64'd5, 64'd3, 1'b0, 64'd0},
		'{GL_HI_MAX,  Top,        1'b0, 64'd0},
		'{64'h0000_FFFF_FFFF_0000, 64'hFFFF_0000_0000_FFFF, 1'b0, 64'd0}
	};

	typedef enum logic [1:0] {RxFlow, RxCoin, RxSparse} rx_mode_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;

	word_t expected_products [$];
	word_t pending_product;
	bit    hold_request = 1'b0;
	int    items_sent = 0;
	int    products_checked = 0;
	int    mismatches = 0;
	int    idle_cycles = 0;
	int    held_cycles = 0;

	goldilocks_mod_multiplier dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic word_t goldilocks_product(word_t a, word_t b);
		logic [127:0] full;
		full = {64'd0, a} * {64'd0, b};
		return word_t'(full % {64'd0, GL_PRIME});
	endfunction

	function automatic word_t rand_operand();
		word_t v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = GL_PRIME + word_t'($urandom_range(0, 64));
			1: v = GL_PRIME - word_t'($urandom_range(1, 64));
			2: v = Top - word_t'($urandom_range(0, 64));
			3: v = word_t'($urandom_range(0, 255));
			4: v = word_t'(1) << $urandom_range(0, 63);
			5: v = {32'hFFFF_FFFF, 32'($urandom)};
			6: v = {32'($urandom), 32'hFFFF_FFFF};
			default: ;
		endcase
		return v;
	endfunction

	task automatic report_mismatch(string what, word_t got, word_t want);
		mismatches++;
		if (mismatches <= MaxReports)
			$display("MISMATCH %s: got %h, expected %h (product %0d)",
				what, got, want, products_checked);
	endtask

	task automatic send_pair(word_t a, word_t b, logic known, word_t product);
		s_axis_tdata  <= {b, a};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		expected_products.push_back(known ? product : goldilocks_product(a, b));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic pause_sender(int gap);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (expected_products.size() == 0) begin
				report_mismatch("item with nothing pending", m_axis_tdata, '0);
			end else begin
				pending_product = expected_products.pop_front();
				if (m_axis_tdata !== pending_product)
					report_mismatch("product_mod_p", m_axis_tdata, pending_product);
				products_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
				(m_axis_tvalid === 1'b1 && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("Timeout after %0d idle cycles, %0d products pending",
					idle_cycles, expected_products.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin : receiver
		int seg_left;
		rx_mode_t mode;
		seg_left = 0;
		mode = RxFlow;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				held_cycles += HoldCycles;
				hold_request = 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					seg_left = $urandom_range(8, 64);
				end
				seg_left--;
				case (mode)
					RxFlow: m_axis_tready <= 1'b1;
					RxCoin: m_axis_tready <= 1'($urandom_range(0, 1));
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		int burst;
		int k;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < DirRows; k++) begin
			send_pair(DirTab[k].op_a, DirTab[k].op_b, DirTab[k].known, DirTab[k].product);
			pause_sender($urandom_range(0, 2));
		end

		while (items_sent < TotalItems) begin
			burst = $urandom_range(1, 24);
			for (k = 0; k < burst && items_sent < TotalItems; k++) begin
				if (items_sent == HoldAtItem)
					hold_request = 1'b1;
				send_pair(rand_operand(), rand_operand(), 1'b0, '0);
			end
			pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
		end
		s_axis_tvalid <= 1'b0;

		while (expected_products.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d operand pairs (%0d directed), checked %0d products mod P",
			items_sent, DirRows, products_checked);
		$display("Output held off for %0d cycles once; %0d mismatches",
			held_cycles, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: goldilocks_mod_multiplier.f
hdl/gmm_pkg.sv
hdl/gmm_mul.sv
hdl/gmm_reduce.sv
hdl/goldilocks_mod_multiplier.sv
tb/sv/tb.sv
